FILE: src/local_mean_threshold_macros.svh
// assertion macros for the local mean threshold block
`ifndef LOCAL_MEAN_THRESHOLD_MACROS_SVH
`define LOCAL_MEAN_THRESHOLD_MACROS_SVH

// same-cycle implication
`define LMT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lmt assertion failed");

// next-cycle implication
`define LMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lmt assertion failed");

`endif

FILE: src/lmt_pkg.sv
// package: transaction types, configuration struct and register indexes
`default_nettype none
package lmt_pkg;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      REG_RADIUS        = 3'd0,
      REG_IMAGE_WIDTH   = 3'd1,
      REG_IMAGE_HEIGHT  = 3'd2,
      REG_GLOBAL_OFFSET = 3'd3,
      REG_RAMP_SLOPE    = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [7:0] value;
      logic       frame_end;
      logic       bad_config;
   } rsp_type;

   typedef struct packed {
      logic [3:0]         radius;
      logic [10:0]        image_width;
      logic [10:0]        image_height;
      logic signed [8:0]  global_offset;
      logic signed [15:0] ramp_slope;
      logic               geometry_ok;
   } cfg_type;
endpackage
`default_nettype wire

FILE: src/lmt_queue.sv
// short job queue between front and back
`default_nettype none
module lmt_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);
   import lmt_pkg::*;
   localparam int PTRW = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [PTRW:0]    count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == (PTRW+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (!do_push && do_pop) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end
endmodule
`default_nettype wire

FILE: src/lmt_front.sv
// front: accepts transactions, tracks frame position, issues jobs
`default_nettype none
module lmt_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_RADIUS = 15,
   localparam int XW   = $clog2(MAX_WIDTH),
   localparam int YOW  = $clog2(MAX_HEIGHT),
   localparam int SLW  = $clog2(2*MAX_RADIUS+1),
   localparam int JOBW = 4 + 8 + SLW + XW + XW + YOW + SLW
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lmt_pkg::cfg_type cfg,
   input  wire logic             restart,
   input  wire logic             req_push,
   input  wire lmt_pkg::req_type req_data,
   output logic                  req_full,
   output logic                  job_push,
   output logic [JOBW-1:0]       job_data,
   input  wire logic             job_full
);
   import lmt_pkg::*;
   localparam int YIW = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
   localparam int PW  = ((XW > YIW) ? ((XW > 11) ? XW : 11) : ((YIW > 11) ? YIW : 11)) + 1;

   typedef struct packed {
      logic           wr;
      logic           emit;
      logic           bad;
      logic           last;
      logic [7:0]     pix;
      logic [SLW-1:0] wslot;
      logic [XW-1:0]  wcol;
      logic [XW-1:0]  ox;
      logic [YOW-1:0] oy;
      logic [SLW-1:0] oslot;
   } job_type;

   logic [XW-1:0]  in_col_ff, ox_ff;
   logic [YIW-1:0] in_row_ff;
   logic [YOW-1:0] oy_ff;
   logic [SLW-1:0] in_slot_ff, oslot_ff;
   logic           accept, wr, emit, last, in_eol, out_eol, in_swrap, out_swrap;
   logic [PW-1:0]  r_p, w_m1, h_m1;
   job_type        job;

   assign req_full  = job_full;
   assign accept    = req_push && !job_full;
   assign r_p       = PW'(cfg.radius);
   assign w_m1      = PW'(cfg.image_width) - PW'(1);
   assign h_m1      = PW'(cfg.image_height) - PW'(1);
   assign wr        = PW'(in_row_ff) < PW'(cfg.image_height);
   assign emit      = (PW'(in_row_ff) > r_p) || ((PW'(in_row_ff) == r_p) && (PW'(in_col_ff) >= r_p));
   assign last      = (PW'(oy_ff) == h_m1) && (PW'(ox_ff) == w_m1);
   assign in_eol    = PW'(in_col_ff) == w_m1;
   assign out_eol   = PW'(ox_ff) == w_m1;
   assign in_swrap  = 6'(in_slot_ff) == {1'b0, cfg.radius, 1'b0};
   assign out_swrap = 6'(oslot_ff) == {1'b0, cfg.radius, 1'b0};

   always_comb begin
      job.wr    = cfg.geometry_ok && wr;
      job.emit  = cfg.geometry_ok && emit;
      job.bad   = !cfg.geometry_ok;
      job.last  = last;
      job.pix   = req_data.cmd ? 8'd0 : req_data.pixel_value;
      job.wslot = in_slot_ff;
      job.wcol  = in_col_ff;
      job.ox    = ox_ff;
      job.oy    = oy_ff;
      job.oslot = oslot_ff;
   end

   assign job_push = accept && (!cfg.geometry_ok || wr || emit);
   assign job_data = job;

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         in_slot_ff <= '0;
         ox_ff      <= '0;
         oy_ff      <= '0;
         oslot_ff   <= '0;
      end else if (accept && cfg.geometry_ok) begin
         if (emit && last) begin
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            in_slot_ff <= '0;
            ox_ff      <= '0;
            oy_ff      <= '0;
            oslot_ff   <= '0;
         end else begin
            if (in_eol) begin
               in_col_ff  <= '0;
               in_row_ff  <= in_row_ff + 1'b1;
               in_slot_ff <= in_swrap ? '0 : in_slot_ff + 1'b1;
            end else begin
               in_col_ff <= in_col_ff + 1'b1;
            end
            if (emit) begin
               if (out_eol) begin
                  ox_ff    <= '0;
                  oy_ff    <= oy_ff + 1'b1;
                  oslot_ff <= out_swrap ? '0 : oslot_ff + 1'b1;
               end else begin
                  ox_ff <= ox_ff + 1'b1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

FILE: src/lmt_back.sv
// back: stores pixels, sums the window, divides and thresholds
`default_nettype none
module lmt_back #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_RADIUS = 15,
   localparam int XW   = $clog2(MAX_WIDTH),
   localparam int YOW  = $clog2(MAX_HEIGHT),
   localparam int SLW  = $clog2(2*MAX_RADIUS+1),
   localparam int JOBW = 4 + 8 + SLW + XW + XW + YOW + SLW
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lmt_pkg::cfg_type cfg,
   input  wire logic [JOBW-1:0]  job_data,
   input  wire logic             job_empty,
   output logic                  job_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output lmt_pkg::rsp_type      rsp_data
);
   import lmt_pkg::*;
   localparam int WN   = 2*MAX_RADIUS + 1;
   localparam int DW   = $clog2(WN + 1);
   localparam int CNTW = $clog2(WN*WN + 1);
   localparam int SW   = 8 + CNTW;
   localparam int DCW  = $clog2(SW + 1);
   localparam int AW   = SLW + XW;
   localparam int PW   = ((XW > YOW) ? ((XW > 11) ? XW : 11) : ((YOW > 11) ? YOW : 11)) + 1;

   typedef struct packed {
      logic           wr;
      logic           emit;
      logic           bad;
      logic           last;
      logic [7:0]     pix;
      logic [SLW-1:0] wslot;
      logic [XW-1:0]  wcol;
      logic [XW-1:0]  ox;
      logic [YOW-1:0] oy;
      logic [SLW-1:0] oslot;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SUM, ST_CENTER, ST_LOAD, ST_DIV, ST_DIFF, ST_MUL, ST_RES, ST_OUT
   } state_type;

   state_type          state_ff;
   job_type            job;
   logic [7:0]         mem [0:(1<<AW)-1];
   logic [7:0]         rd_ff, pix_ff;
   logic [AW-1:0]      rd_addr, center_ff;
   logic [XW-1:0]      col_ff;
   logic [SLW-1:0]     slot_ff, slot0_ff;
   logic [DW-1:0]      rowcnt_ff, colcnt_ff, nx_ff, ny_ff;
   logic [CNTW-1:0]    count_ff;
   logic [SW-1:0]      acc_ff, dq_ff;
   logic [CNTW:0]      rem_ff, remsh;
   logic [DCW-1:0]     dcnt_ff;
   logic               acc_vld_ff, last_ff, bad_ff;
   logic signed [10:0] diff_ff;
   logic signed [26:0] prod_ff;
   logic signed [19:0] qv;
   logic [7:0]         res_ff;
   logic               out_vld_ff;
   rsp_type            out_ff;
   logic [PW-1:0]      r_p, x0, x1, y0, y1, xr, yr;
   logic [5:0]         slot0;
   logic               out_free;

   assign job       = job_type'(job_data);
   assign job_pop   = (state_ff == ST_IDLE) && !job_empty;
   assign rsp_empty = !out_vld_ff;
   assign rsp_data  = out_ff;
   assign out_free  = !out_vld_ff || rsp_pop;

   assign r_p = PW'(cfg.radius);
   assign xr  = PW'(job.ox) + r_p;
   assign yr  = PW'(job.oy) + r_p;
   assign x0  = (PW'(job.ox) >= r_p) ? PW'(job.ox) - r_p : '0;
   assign y0  = (PW'(job.oy) >= r_p) ? PW'(job.oy) - r_p : '0;
   assign x1  = (xr < PW'(cfg.image_width)) ? xr : PW'(cfg.image_width) - PW'(1);
   assign y1  = (yr < PW'(cfg.image_height)) ? yr : PW'(cfg.image_height) - PW'(1);

   always_comb begin
      if (PW'(job.oy) < r_p) slot0 = '0;
      else if (6'(job.oslot) >= 6'(cfg.radius)) slot0 = 6'(job.oslot) - 6'(cfg.radius);
      else slot0 = 6'(job.oslot) + 6'(cfg.radius) + 6'd1;
   end

   assign rd_addr = (state_ff == ST_CENTER) ? center_ff : {slot_ff, col_ff};
   assign remsh   = {rem_ff[CNTW-1:0], dq_ff[SW-1]};
   assign qv      = 20'($signed(prod_ff[26:8])) + 20'sd128;

   always_ff @(posedge clock) begin
      if (job_pop && job.wr) mem[{job.wslot, job.wcol}] <= job.pix;
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         out_vld_ff <= 1'b0;
         acc_vld_ff <= 1'b0;
      end else begin
         if (rsp_pop && out_vld_ff && (state_ff != ST_OUT)) out_vld_ff <= 1'b0;
         acc_vld_ff <= (state_ff == ST_SUM);
         if (acc_vld_ff) acc_ff <= acc_ff + SW'(rd_ff);
         unique case (state_ff)
            ST_IDLE: begin
               if (job_pop) begin
                  acc_ff    <= '0;
                  last_ff   <= job.last;
                  bad_ff    <= job.bad;
                  col_ff    <= XW'(x0);
                  slot_ff   <= SLW'(slot0);
                  slot0_ff  <= SLW'(slot0);
                  nx_ff     <= DW'(x1 - x0 + PW'(1));
                  ny_ff     <= DW'(y1 - y0 + PW'(1));
                  count_ff  <= CNTW'(x1 - x0 + PW'(1)) * CNTW'(y1 - y0 + PW'(1));
                  rowcnt_ff <= '0;
                  colcnt_ff <= '0;
                  center_ff <= {job.oslot, job.ox};
                  if (job.bad) begin
                     res_ff   <= 8'd0;
                     state_ff <= ST_OUT;
                  end else if (job.emit) begin
                     state_ff <= ST_SUM;
                  end
               end
            end
            ST_SUM: begin
               if (rowcnt_ff == ny_ff - 1'b1) begin
                  rowcnt_ff <= '0;
                  slot_ff   <= slot0_ff;
                  col_ff    <= col_ff + 1'b1;
                  colcnt_ff <= colcnt_ff + 1'b1;
                  if (colcnt_ff == nx_ff - 1'b1) state_ff <= ST_CENTER;
               end else begin
                  rowcnt_ff <= rowcnt_ff + 1'b1;
                  slot_ff   <= (6'(slot_ff) == {1'b0, cfg.radius, 1'b0}) ? '0 : slot_ff + 1'b1;
               end
            end
            ST_CENTER: state_ff <= ST_LOAD;
            ST_LOAD: begin
               pix_ff   <= rd_ff;
               dq_ff    <= acc_ff;
               rem_ff   <= '0;
               dcnt_ff  <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (remsh >= {1'b0, count_ff}) begin
                  rem_ff <= remsh - {1'b0, count_ff};
                  dq_ff  <= {dq_ff[SW-2:0], 1'b1};
               end else begin
                  rem_ff <= remsh;
                  dq_ff  <= {dq_ff[SW-2:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == DCW'(SW - 1)) state_ff <= ST_DIFF;
            end
            ST_DIFF: begin
               diff_ff  <= $signed({3'b000, pix_ff}) - $signed({3'b000, dq_ff[7:0]})
                           - 11'(cfg.global_offset);
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               prod_ff  <= cfg.ramp_slope * diff_ff;
               state_ff <= ST_RES;
            end
            ST_RES: begin
               if (cfg.ramp_slope == '0) res_ff <= (diff_ff < 0) ? 8'd0 : 8'd255;
               else if (qv < 0) res_ff <= 8'd0;
               else if (qv > 20'sd255) res_ff <= 8'd255;
               else res_ff <= qv[7:0];
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  out_vld_ff          <= 1'b1;
                  out_ff.value        <= res_ff;
                  out_ff.frame_end    <= !bad_ff && last_ff;
                  out_ff.bad_config   <= bad_ff;
                  state_ff            <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: src/local_mean_threshold.sv
// top level: register file, front, job queue and back
//
// Pixels of one channel enter in raster order through the request queue
// port (req_push/req_full); each transaction carries a pixel or a flush
// command. Thresholded pixels leave through the response queue port
// (rsp_empty/rsp_pop). Result k comes out with request k + r*W + r of the
// frame; flush requests drain the last r*W + r results.
// Registers are to be written through csr_we/csr_index/csr_wdata only
// while idle, which the block itself does not enforce; a geometry write
// restarts the frame. A request is taken into a four-entry job queue.
// The back end takes one job at a time. For a pixel that yields a result
// it reads each window pixel inside the image, at most (2r+1)^2, from the
// store (one store read a cycle), then runs the restoring divider (one
// quotient bit a cycle); a job with no result leaves the back end idle.
// A result waits in the output register while rsp_pop is low; the back
// end then holds, the job queue fills and req_full rises.
// Synchronous reset empties all queues, clears the frame position and
// loads the register defaults; the pixel store needs no clearing.
`default_nettype none
module local_mean_threshold #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_RADIUS = 15
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire lmt_pkg::req_type req_data,
   output logic                  req_full,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output lmt_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [2:0]       csr_index,
   input  wire logic [15:0]      csr_wdata
);
   import lmt_pkg::*;
   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int YOW  = $clog2(MAX_HEIGHT);
   localparam int SLW  = $clog2(2*MAX_RADIUS+1);
   localparam int JOBW = 4 + 8 + SLW + XW + XW + YOW + SLW;

   logic [3:0]         radius_ff;
   logic [10:0]        width_ff, height_ff, twice_r;
   logic signed [8:0]  offset_ff;
   logic signed [15:0] slope_ff;
   cfg_type            cfg;
   logic               restart, job_push, job_full, job_pop, job_empty;
   logic [JOBW-1:0]    job_in, job_out;

   assign twice_r = {6'd0, radius_ff, 1'b0};
   assign restart = csr_we && ((csr_index == REG_RADIUS) || (csr_index == REG_IMAGE_WIDTH)
                              || (csr_index == REG_IMAGE_HEIGHT));

   always_comb begin
      cfg.radius        = radius_ff;
      cfg.image_width   = width_ff;
      cfg.image_height  = height_ff;
      cfg.global_offset = offset_ff;
      cfg.ramp_slope    = slope_ff;
      cfg.geometry_ok   = (32'(radius_ff) <= MAX_RADIUS) && (width_ff != '0)
                          && (32'(width_ff) <= MAX_WIDTH) && (height_ff != '0)
                          && (32'(height_ff) <= MAX_HEIGHT)
                          && (width_ff > twice_r) && (height_ff > twice_r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 4'd2;
         width_ff  <= 11'd640;
         height_ff <= 11'd480;
         offset_ff <= '0;
         slope_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_RADIUS:        radius_ff <= csr_wdata[3:0];
            REG_IMAGE_WIDTH:   width_ff  <= csr_wdata[10:0];
            REG_IMAGE_HEIGHT:  height_ff <= csr_wdata[10:0];
            REG_GLOBAL_OFFSET: offset_ff <= csr_wdata[8:0];
            REG_RAMP_SLOPE:    slope_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   lmt_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_RADIUS(MAX_RADIUS))
   u_front (
      .clock, .reset, .cfg, .restart, .req_push, .req_data, .req_full,
      .job_push, .job_data(job_in), .job_full
   );

   lmt_queue #(.WIDTH(JOBW)) u_queue (
      .clock, .reset, .push(job_push), .push_data(job_in), .full(job_full),
      .pop(job_pop), .pop_data(job_out), .empty(job_empty)
   );

   lmt_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_RADIUS(MAX_RADIUS))
   u_back (
      .clock, .reset, .cfg, .job_data(job_out), .job_empty, .job_pop,
      .rsp_empty, .rsp_pop, .rsp_data
   );
endmodule
`default_nettype wire

FILE: src/lmt_checker.sv
// port-level checker for the local mean threshold block, with its bind
`default_nettype none
`include "local_mean_threshold_macros.svh"
module lmt_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_empty,
   input wire logic             rsp_pop,
   input wire lmt_pkg::rsp_type rsp_data
);
   import lmt_pkg::*;

   `LMT_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data))
   `LMT_ASSERT_NOW(a_bad_zero, clock, reset, !rsp_empty && rsp_data.bad_config, rsp_data.value == 8'd0 && !rsp_data.frame_end)
   `LMT_ASSERT_NOW(a_empty_after_reset, clock, reset, $past(reset), rsp_empty)
endmodule

bind local_mean_threshold lmt_checker u_checker (
   .clock, .reset, .rsp_empty, .rsp_pop, .rsp_data
);
`default_nettype wire

FILE: tb/sv/testbench.sv
// testbench for local_mean_threshold: scoreboard with window predictor, queue drivers
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import lmt_pkg::*;

   class threshold_scoreboard;
      bit [7:0] pixel_rows [0:31743];
      bit [3:0] radius;
      bit [10:0] width;
      bit [10:0] height;
      logic signed [8:0] offset;
      logic signed [15:0] slope;
      int unsigned col, row, out_idx;
      rsp_type expected_q[$];
      int errors;
      int checked;

      function new();
         foreach (pixel_rows[i]) pixel_rows[i] = 8'd0;
         radius = 4'd2;
         width = 11'd640;
         height = 11'd480;
         offset = 9'sd0;
         slope = 16'sd0;
         restart();
         errors = 0;
         checked = 0;
      endfunction

      function void restart();
         col = 0;
         row = 0;
         out_idx = 0;
      endfunction

      function void write_reg(reg_index_type idx, bit [15:0] v);
         case (idx)
            REG_RADIUS: begin
               radius = v[3:0];
               restart();
            end
            REG_IMAGE_WIDTH: begin
               width = v[10:0];
               restart();
            end
            REG_IMAGE_HEIGHT: begin
               height = v[10:0];
               restart();
            end
            REG_GLOBAL_OFFSET: offset = v[8:0];
            REG_RAMP_SLOPE: slope = v;
            default: ;
         endcase
      endfunction

      function bit geometry_ok();
         if (width == 0 || width > 1024 || height == 0 || height > 1024) return 0;
         if (width <= 2 * radius || height <= 2 * radius) return 0;
         return 1;
      endfunction

      function int unsigned slot(int unsigned y, int unsigned x);
         return (y % (2 * radius + 1)) * 1024 + x;
      endfunction

      function bit [7:0] window_value(int unsigned k);
         int unsigned y, x, y0, y1, x0, x1, count, total;
         int mean, pix, diff;
         longint prod;
         y = k / width;
         x = k % width;
         y0 = (y >= radius) ? y - radius : 0;
         y1 = (y + radius < height) ? y + radius : height - 1;
         x0 = (x >= radius) ? x - radius : 0;
         x1 = (x + radius < width) ? x + radius : width - 1;
         count = (y1 - y0 + 1) * (x1 - x0 + 1);
         total = 0;
         for (int unsigned c = x0; c <= x1; c++)
            for (int unsigned rr = y0; rr <= y1; rr++)
               total += pixel_rows[slot(rr, c)];
         mean = total / count;
         pix = pixel_rows[slot(y, x)];
         if (slope == 0) return (pix < mean + offset) ? 8'd0 : 8'd255;
         diff = pix - mean - offset;
         prod = longint'(slope) * longint'(diff);
         prod = (prod >>> 8) + 128;
         if (prod < 0) prod = 0;
         if (prod > 255) prod = 255;
         return prod[7:0];
      endfunction

      function void note_request(req_type d);
         int unsigned t, lag, total;
         rsp_type e;
         if (!geometry_ok()) begin
            e.value = 8'd0;
            e.frame_end = 1'b0;
            e.bad_config = 1'b1;
            expected_q.push_back(e);
            return;
         end
         total = width * height;
         lag = radius * width + radius;
         t = row * width + col;
         if (t < total) pixel_rows[slot(row, col)] = d.cmd ? 8'd0 : d.pixel_value;
         if (t >= lag) begin
            e.value = window_value(out_idx % total);
            e.frame_end = (out_idx >= total - 1);
            e.bad_config = 1'b0;
            expected_q.push_back(e);
            if (e.frame_end) begin
               restart();
               return;
            end
            out_idx++;
         end
         col++;
         if (col >= width) begin
            col = 0;
            row++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         checked++;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected transaction value %0d frame_end %0d bad_config %0d",
                     $time, got.value, got.frame_end, got.bad_config);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (got.value !== e.value) begin
            $display("%0t: value expected %0d actual %0d", $time, e.value, got.value);
            errors++;
         end
         if (got.frame_end !== e.frame_end) begin
            $display("%0t: frame_end expected %0d actual %0d", $time, e.frame_end,
                     got.frame_end);
            errors++;
         end
         if (got.bad_config !== e.bad_config) begin
            $display("%0t: bad_config expected %0d actual %0d", $time, e.bad_config,
                     got.bad_config);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   req_type req_data = '0;
   logic req_full;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = 3'd0;
   logic [15:0] csr_wdata = 16'd0;

   threshold_scoreboard sb = new();
   bit idling = 1'b1;
   int items_sent = 0;
   int watchdog = 0;

   local_mean_threshold dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_we || reset)
         watchdog <= 0;
      else
         watchdog <= watchdog + 1;
      if (watchdog >= 20000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      @(negedge reset);
      forever begin
         if (idling && $urandom_range(0, 7) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         if (!rsp_empty) sb.check_response(rsp_data);
      end
   end

   task automatic configure(int r, int w, int h, int off, int slp);
      bit [15:0] vals [5];
      reg_index_type idx;
      vals = '{16'(r), 16'(w), 16'(h), 16'(off), 16'(slp)};
      for (int i = 0; i < 5; i++) begin
         idx = reg_index_type'(i);
         csr_we <= 1'b1;
         csr_index <= idx;
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.write_reg(idx, vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   task automatic push_item(bit cmd, bit [7:0] pix);
      req_type d;
      if (idling && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      d.cmd = cmd;
      d.pixel_value = pix;
      req_data <= d;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      sb.note_request(d);
      items_sent++;
   endtask

   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (2100) @(posedge clock);
   endtask

   function automatic bit [7:0] random_pixel(int band);
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'(band + $urandom_range(0, 15));
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic stream_frame(int n, bit pause_midway);
      int band;
      band = $urandom_range(0, 240);
      for (int i = 0; i < n; i++) begin
         if (pause_midway && i == n / 2) begin
            req_push <= 1'b0;
            @(posedge clock);
            while (sb.expected_q.size() != 0) @(posedge clock);
         end
         push_item($urandom_range(0, 9) == 0, random_pixel(band));
      end
   endtask

   initial begin
      int r, w, h, off, slp, n, random_start;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // binary mode on a 3x3 frame, flush inside the pixel phase
      configure(1, 3, 3, 0, 0);
      push_item(0, 8'd0);
      push_item(0, 8'd255);
      push_item(1, 8'd255);
      push_item(0, 8'd128);
      push_item(0, 8'd127);
      push_item(0, 8'd1);
      push_item(0, 8'd254);
      push_item(0, 8'd255);
      push_item(0, 8'd0);
      for (int i = 0; i < 4; i++) push_item(i[0], 8'hAA);
      drain();
      // unusable geometry
      configure(1, 2, 3, 0, 0);
      push_item(0, 8'd255);
      push_item(1, 8'd0);
      drain();
      // ramp extremes, pixels after the last pixel, frame wrap
      configure(0, 2, 2, 255, -32768);
      for (int i = 0; i < 6; i++) push_item(0, i[0] ? 8'd255 : 8'd0);
      drain();
      configure(0, 2, 2, -255, 32767);
      for (int i = 0; i < 5; i++) push_item(i == 2, i[0] ? 8'd0 : 8'd255);
      drain();

      // geometry extremes
      configure(0, 1024, 1, 17, 0);
      stream_frame(60, 1'b0);
      drain();
      configure(0, 1, 1024, -3, 300);
      stream_frame(60, 1'b0);
      drain();
      configure(15, 31, 31, 0, 256);
      stream_frame(490, 1'b0);
      drain();
      configure(0, 2047, 4, 0, 0);
      stream_frame(3, 1'b0);
      drain();
      configure(0, 4, 0, 0, 0);
      stream_frame(3, 1'b0);
      drain();

      random_start = items_sent;
      while (items_sent - random_start < 250) begin
         if (items_sent - random_start > 200) idling = 1'b0;
         r = $urandom_range(0, 3);
         w = $urandom_range(2 * r + 1, 12);
         h = $urandom_range(2 * r + 1, 10);
         case ($urandom_range(0, 3))
            0: off = -255;
            1: off = 255;
            default: off = $urandom_range(0, 60) - 30;
         endcase
         slp = $urandom_range(0, 1) ? 0 : int'($urandom_range(0, 65535)) - 32768;
         if ($urandom_range(0, 15) == 0) w = 2 * r;
         configure(r, w, h, off, slp);
         n = w * h + r * w + r;
         case ($urandom_range(0, 5))
            0: n = $urandom_range(1, n);
            1: n = n + $urandom_range(1, 10);
            default: ;
         endcase
         stream_frame(n, items_sent == random_start);
         drain();
      end

      $display("ran %0d transactions over binary, ramp and unusable geometry settings,",
               items_sent);
      $display("%0d results compared, radius 0 to 15, widths and heights up to 1024",
               sb.checked);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
